### hdl/sdra_pkg.sv
// Shared types and character codes for the signed decimal right-aligned formatter.
// No dependencies.
`default_nettype none

package sdra_pkg;

   localparam int CHAR_W  = 6;
   localparam int FIELD_W = 4;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [FIELD_W-1:0] field_width_type;

   localparam char_type CH_SPACE = 6'h20;
   localparam char_type CH_MINUS = 6'h2D;
   localparam char_type CH_ZERO  = 6'h30;

endpackage

`default_nettype wire

### hdl/signed_decimal_right_aligned_core.sv
// Signed binary to right-aligned ASCII decimal field, one character per output item.
// Depends on sdra_pkg (character codes, types).
`default_nettype none

// Usage:
//   req channel: one item = a signed value and a field width (0 is taken as 1,
//   anything above MAX_WIDTH as MAX_WIDTH). Items are taken whenever the
//   pipeline has room, one per cycle at most.
//   rsp channel: the field's characters, left to right, one per item, with
//   rsp_last_char high on the rightmost one.
//   Path: the input register loads at the accepting edge, then come NS
//   binary-to-BCD stages of four bits each, a format stage and the output
//   serializer, which shows the first character of the item.
//   Output: the serializer sends an item's characters, as many as its field
//   width, 1 to MAX_WIDTH, one character per cycle while rsp_ready is high.
//   While it drains, later items keep moving down the pipeline.
//   Reset clears every stage's valid bit and the serializer's valid bit and count; nothing else.
//   When the receiver stalls, the serializer holds its character and the
//   pipeline fills up behind it, then req_ready drops; nothing is lost.
module signed_decimal_right_aligned_core #(
   parameter int VALUE_BITS = 16,
   parameter int MAX_WIDTH  = 9
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic signed [VALUE_BITS-1:0]    req_value,
   input  wire sdra_pkg::field_width_type       req_field_width,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output sdra_pkg::char_type                   rsp_char_code,
   output logic                                 rsp_last_char
);

   // digits of the largest magnitude, 2^(VALUE_BITS-1)
   function automatic int num_digits(input int bits);
      longint unsigned x;
      int              n;
      x = 64'd1 << (bits - 1);
      n = 1;
      for (int i = 0; i < 20; i++) begin
         if (x >= 10) begin
            x = x / 10;
            n = n + 1;
         end
      end
      return n;
   endfunction

   localparam int BPS  = 4;
   localparam int NS   = (VALUE_BITS + BPS - 1) / BPS;
   localparam int PADW = NS * BPS;
   localparam int ND   = num_digits(VALUE_BITS);
   localparam int BCDW = 4 * ND;
   localparam int WDW  = $clog2(MAX_WIDTH + 1);
   localparam int NDW  = $clog2(ND + 1);
   localparam int CW   = (NDW > WDW) ? NDW : WDW;

   // one double-dabble step: add 3 to digits >= 5, then shift in a bit
   function automatic logic [BCDW-1:0] dd_step(input logic [BCDW-1:0] b,
                                                input logic bit_in);
      logic [BCDW-1:0] t;
      t = b;
      for (int j = 0; j < ND; j++) begin
         if (t[j*4 +: 4] >= 4'd5) begin
            t[j*4 +: 4] = t[j*4 +: 4] + 4'd3;
         end
      end
      return {t[BCDW-2:0], bit_in};
   endfunction

   // ---------------- conversion pipeline ----------------
   logic [NS:0]         st_valid_ff;
   logic [NS:0]         st_valid_in;
   logic [NS:0]         st_rdy;
   logic [PADW-1:0]     st_bin_ff [0:NS];
   logic [PADW-1:0]     st_bin_in [0:NS];
   logic [BCDW-1:0]     st_bcd_ff [0:NS];
   logic [BCDW-1:0]     st_bcd_in [0:NS];
   logic [NS:0]         st_neg_ff;
   logic [NS:0]         st_neg_in;
   logic [WDW-1:0]      st_wid_ff [0:NS];
   logic [WDW-1:0]      st_wid_in [0:NS];

   logic [VALUE_BITS-1:0] mag;
   logic [WDW-1:0]        wid_clamped;

   // format stage
   logic                fmt_valid_ff;
   logic                fmt_rdy;
   logic [BCDW-1:0]     fmt_bcd_ff;
   logic                fmt_neg_ff;
   logic [WDW-1:0]      fmt_wid_ff;
   logic [NDW-1:0]      fmt_nd_ff;
   logic [NDW-1:0]      fmt_nd_in;
   logic [WDW-1:0]      fmt_mpos_ff;
   logic [WDW-1:0]      fmt_mpos_in;

   // serializer
   logic                ser_valid_ff;
   logic                ser_rdy;
   logic                ser_done;
   logic                ser_load;
   logic [WDW-1:0]      ser_cnt_ff;
   sdra_pkg::char_type  ser_char_ff [0:MAX_WIDTH-1];
   sdra_pkg::char_type  ser_char_in [0:MAX_WIDTH-1];

   assign mag = req_value[VALUE_BITS-1]
              ? (~$unsigned(req_value) + {{(VALUE_BITS-1){1'b0}}, 1'b1})
              : $unsigned(req_value);

   always_comb begin
      if (req_field_width == '0) begin
         wid_clamped = WDW'(1);
      end else if (req_field_width > sdra_pkg::FIELD_W'(MAX_WIDTH)) begin
         wid_clamped = WDW'(MAX_WIDTH);
      end else begin
         wid_clamped = WDW'(req_field_width);
      end
   end

   // backpressure: a stage moves when it is empty or the next one moves
   always_comb begin
      st_rdy[NS] = !st_valid_ff[NS] || fmt_rdy;
      for (int k = NS - 1; k >= 0; k--) begin
         st_rdy[k] = !st_valid_ff[k] || st_rdy[k+1];
      end
   end

   assign req_ready = st_rdy[0];

   always_comb begin
      logic [BCDW-1:0] tb;
      logic [PADW-1:0] tbin;
      st_valid_in[0] = req_valid;
      st_bin_in[0]   = PADW'(mag);
      st_bcd_in[0]   = '0;
      st_neg_in[0]   = req_value[VALUE_BITS-1];
      st_wid_in[0]   = wid_clamped;
      for (int k = 1; k <= NS; k++) begin
         tb   = st_bcd_ff[k-1];
         tbin = st_bin_ff[k-1];
         for (int j = 0; j < BPS; j++) begin
            tb   = dd_step(tb, tbin[PADW-1]);
            tbin = {tbin[PADW-2:0], 1'b0};
         end
         st_valid_in[k] = st_valid_ff[k-1];
         st_bin_in[k]   = tbin;
         st_bcd_in[k]   = tb;
         st_neg_in[k]   = st_neg_ff[k-1];
         st_wid_in[k]   = st_wid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= '0;
      end else begin
         for (int k = 0; k <= NS; k++) begin
            if (st_rdy[k]) begin
               st_valid_ff[k] <= st_valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (st_rdy[k] && st_valid_in[k]) begin
            st_bin_ff[k] <= st_bin_in[k];
            st_bcd_ff[k] <= st_bcd_in[k];
            st_neg_ff[k] <= st_neg_in[k];
            st_wid_ff[k] <= st_wid_in[k];
         end
      end
   end

   // ---------------- format stage ----------------
   // digit count (zero counts as one digit) and minus position
   always_comb begin
      logic [CW-1:0] nd_ext;
      logic [CW-1:0] w_ext;
      fmt_nd_in = NDW'(1);
      for (int j = 0; j < ND; j++) begin
         if (st_bcd_ff[NS][j*4 +: 4] != 4'd0) begin
            fmt_nd_in = NDW'(j + 1);
         end
      end
      nd_ext = CW'(fmt_nd_in);
      w_ext  = CW'(st_wid_ff[NS]);
      // when the digits fill the field the sign takes position 0
      if (nd_ext >= w_ext) begin
         fmt_mpos_in = '0;
      end else begin
         fmt_mpos_in = WDW'(w_ext - nd_ext - CW'(1));
      end
   end

   assign fmt_rdy = !fmt_valid_ff || ser_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_valid_ff <= 1'b0;
      end else if (fmt_rdy) begin
         fmt_valid_ff <= st_valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (fmt_rdy && st_valid_ff[NS]) begin
         fmt_bcd_ff  <= st_bcd_ff[NS];
         fmt_neg_ff  <= st_neg_ff[NS];
         fmt_wid_ff  <= st_wid_ff[NS];
         fmt_nd_ff   <= fmt_nd_in;
         fmt_mpos_ff <= fmt_mpos_in;
      end
   end

   // ---------------- serializer ----------------
   always_comb begin
      logic [WDW-1:0] rpos;
      logic [3:0]     dig;
      for (int p = 0; p < MAX_WIDTH; p++) begin
         rpos = fmt_wid_ff - WDW'(p) - WDW'(1);
         dig  = 4'd0;
         for (int j = 0; j < ND; j++) begin
            if (CW'(rpos) == CW'(j)) begin
               dig = fmt_bcd_ff[j*4 +: 4];
            end
         end
         if (WDW'(p) >= fmt_wid_ff) begin
            ser_char_in[p] = sdra_pkg::CH_SPACE;
         end else if (fmt_neg_ff && (WDW'(p) == fmt_mpos_ff)) begin
            ser_char_in[p] = sdra_pkg::CH_MINUS;
         end else if (CW'(rpos) < CW'(fmt_nd_ff)) begin
            ser_char_in[p] = sdra_pkg::CH_ZERO | sdra_pkg::char_type'(dig);
         end else begin
            ser_char_in[p] = sdra_pkg::CH_SPACE;
         end
      end
   end

   assign ser_done = ser_valid_ff && rsp_ready && (ser_cnt_ff == WDW'(1));
   assign ser_rdy  = !ser_valid_ff || ser_done;
   assign ser_load = fmt_valid_ff && ser_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_cnt_ff   <= '0;
      end else if (ser_load) begin
         ser_valid_ff <= 1'b1;
         ser_cnt_ff   <= fmt_wid_ff;
      end else if (ser_valid_ff && rsp_ready) begin
         ser_valid_ff <= !ser_done;
         ser_cnt_ff   <= ser_cnt_ff - WDW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_char_ff <= ser_char_in;
      end else if (ser_valid_ff && rsp_ready) begin
         for (int p = 0; p < MAX_WIDTH - 1; p++) begin
            ser_char_ff[p] <= ser_char_ff[p+1];
         end
         ser_char_ff[MAX_WIDTH-1] <= sdra_pkg::CH_SPACE;
      end
   end

   assign rsp_valid     = ser_valid_ff;
   assign rsp_char_code = ser_char_ff[0];
   assign rsp_last_char = (ser_cnt_ff == WDW'(1));

`ifndef SYNTH
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_cnt_ff != '0) && (ser_cnt_ff <= WDW'(MAX_WIDTH)))
      else $error("serializer count out of range while busy");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (ser_done && !fmt_valid_ff) |=> !rsp_valid)
      else $error("output still valid after last character with nothing queued");

   a_sign_pos: assert property (@(posedge clock) disable iff (reset)
      fmt_valid_ff |-> (fmt_mpos_ff < fmt_wid_ff))
      else $error("minus position outside the field");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff[NS] && !st_rdy[NS]) |=> (st_valid_ff[NS] && $stable(st_bcd_ff[NS])))
      else $error("last conversion stage lost its item during a stall");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for signed_decimal_right_aligned_core: value and width items in,
// checked one ASCII character item at a time. Depends on sdra_pkg and the core.
`timescale 1ns / 100ps

module testbench;

   localparam int VALUE_BITS     = 16;
   localparam int MAX_WIDTH      = 9;
   localparam int CLOCK_PERIOD   = 20;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int LONG_HOLD      = 300;

   typedef struct packed {
      sdra_pkg::char_type code;
      logic               last;
   } char_item_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic signed [VALUE_BITS-1:0]   req_value;
   sdra_pkg::field_width_type      req_field_width;
   logic                           rsp_valid;
   logic                           rsp_ready;
   sdra_pkg::char_type             rsp_char_code;
   logic                           rsp_last_char;

   char_item_type expected_chars[$];
   int         errors        = 0;
   int         values_sent   = 0;
   int         chars_checked = 0;
   bit         idle_on       = 1'b0;
   int         long_hold_req = 0;

   signed_decimal_right_aligned_core #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_field_width (req_field_width),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_code   (rsp_char_code),
      .rsp_last_char   (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("FAIL");
      $finish;
   end

   // Builds the characters of one field and queues them, left to right.
   function automatic void format_field(input logic signed [VALUE_BITS-1:0] value,
                                        input sdra_pkg::field_width_type width);
      logic [VALUE_BITS:0] mag;
      logic                neg;
      int                  w;
      int                  pos;
      sdra_pkg::char_type  field_text [MAX_WIDTH];
      char_item_type       item;
      neg = value[VALUE_BITS-1];
      mag = neg ? ({(VALUE_BITS+1){1'b0}} - {value[VALUE_BITS-1], value})
                : {1'b0, value};
      w = int'(width);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      for (int k = 0; k < MAX_WIDTH; k++) field_text[k] = sdra_pkg::CH_SPACE;
      pos = w - 1;
      while (1) begin
         field_text[pos] = sdra_pkg::CH_ZERO + sdra_pkg::char_type'(mag % 10);
         mag = mag / 10;
         if (pos == 0) break;
         pos--;
         if (mag == 0) break;
      end
      // pos is left of the digits, or 0 when they fill the field
      if (neg) field_text[pos] = sdra_pkg::CH_MINUS;
      for (int k = 0; k < w; k++) begin
         item.code = field_text[k];
         item.last = (k == w - 1);
         expected_chars.push_back(item);
      end
   endfunction

   // Receiver: random stall bursts, plus a long hold when one is requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req != 0) begin
            stall_left    = long_hold_req;
            long_hold_req = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      char_item_type exp_item;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected char item: char_code %h last_char %b",
                   rsp_char_code, rsp_last_char);
            errors++;
         end else begin
            exp_item = expected_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== exp_item.code) begin
               $error("char_code: expected %h, actual %h", exp_item.code, rsp_char_code);
               errors++;
            end
            if (rsp_last_char !== exp_item.last) begin
               $error("last_char: expected %b, actual %b", exp_item.last, rsp_last_char);
               errors++;
            end
         end
      end
   end

   // Call at a rising edge; returns at the edge where the item is taken.
   task automatic send_value(input logic signed [VALUE_BITS-1:0] value,
                             input sdra_pkg::field_width_type width);
      req_valid       <= 1'b1;
      req_value       <= value;
      req_field_width <= width;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      format_field(value, width);
      values_sent++;
   endtask

   task automatic sender_idle();
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      logic signed [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 3))
         0: v = VALUE_BITS'($urandom);
         1: v = VALUE_BITS'($urandom_range(0, 99));
         2: v = VALUE_BITS'($urandom_range(32700, 32768));
         default: v = VALUE_BITS'($urandom_range(0, 9999));
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   function automatic sdra_pkg::field_width_type random_width();
      if ($urandom_range(0, 7) == 0) begin
         return sdra_pkg::field_width_type'($urandom_range(0, 15));
      end
      return sdra_pkg::field_width_type'($urandom_range(1, MAX_WIDTH));
   endfunction

   task automatic test_directed();
      send_value(16'sd0, 4'd1);
      send_value(16'sd0, 4'd9);
      send_value(16'sd0, 4'd0);            // zero width taken as one
      send_value(16'sd32767, 4'd9);
      send_value(16'sd32767, 4'd5);
      send_value(16'sd32767, 4'd3);        // narrow: low digits kept
      send_value(-16'sd32768, 4'd9);
      send_value(-16'sd32768, 4'd6);
      send_value(-16'sd32768, 4'd5);       // digits fill, minus overwrites the first
      send_value(-16'sd32768, 4'd1);
      send_value(-16'sd1, 4'd1);
      send_value(-16'sd1, 4'd2);
      send_value(16'sd1, 4'd0);
      send_value(16'sd123, 4'd15);         // saturates at MAX_WIDTH
      send_value(-16'sd45, 4'd10);
      send_value(16'sd5, 4'd11);
      send_value(-16'sd7, 4'd12);
      send_value(16'sd99, 4'd13);
      send_value(-16'sd999, 4'd14);
      send_value(16'sd12345, 4'd3);
      send_value(-16'sd12345, 4'd4);
      send_value(16'sh5555, 4'd7);
      send_value(16'shAAAA, 4'd8);
      send_value(16'sd10, 4'd2);
      wait_drained();
   endtask

   task automatic test_random();
      idle_on = 1'b1;
      repeat (167) begin
         send_value(random_value(), random_width());
         sender_idle();
      end
      wait_drained();
   endtask

   // Receiver holds off while items keep coming, so the pipe fills and req_ready drops.
   task automatic test_backpressure();
      idle_on       = 1'b0;
      long_hold_req = LONG_HOLD;
      repeat (24) begin
         send_value(random_value(),
                    sdra_pkg::field_width_type'($urandom_range(1, MAX_WIDTH)));
      end
      wait_drained();
   endtask

   task automatic test_pause_until_empty();
      idle_on = 1'b1;
      repeat (3) begin
         repeat (5) begin
            send_value(random_value(), random_width());
            sender_idle();
         end
         wait_drained();
      end
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      repeat (30) send_value(random_value(), random_width());
      wait_drained();
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_value       <= '0;
      req_field_width <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random();
      test_backpressure();
      test_pause_until_empty();
      test_full_rate();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $error("%0d char items never arrived", expected_chars.size());
         errors++;
      end
      $display("Formatted %0d values into %0d checked characters: extremes, widths 0..15,",
               values_sent, chars_checked);
      $display("random stalls on both sides, a long output hold and full-rate streaming.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
